>>> sv/psp_pkg.sv
package psp_pkg;

   localparam int COORD_WIDTH_DEF = 20;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [1:0] VERTEX_COUNT_MAX = 2'd3;
   localparam logic [1:0] MIN_POLY_VERTS = 2'd2;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_RECT_MODE    = 3'd0,
      CSR_PICK_X       = 3'd1,
      CSR_PICK_Y       = 3'd2,
      CSR_RECT_MAX_X   = 3'd3,
      CSR_RECT_MAX_Y   = 3'd4,
      CSR_COMBINE_MODE = 3'd5
   } csr_addr_type;

   typedef enum logic [1:0] {
      COMBINE_NEW       = 2'd0,
      COMBINE_JOIN      = 2'd1,
      COMBINE_INTERSECT = 2'd2,
      COMBINE_INVERT    = 2'd3
   } combine_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic was_selected;
      logic edge_ok;
      logic enough;
      logic in_rect;
   } ctrl_type;

endpackage

>>> sv/psp_req_if.sv
interface psp_req_if import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vert_x;
   logic signed [COORD_WIDTH-1:0] vert_y;
   logic                          last_vertex;
   logic                          was_selected;

   modport source (output valid, vert_x, vert_y, last_vertex, was_selected, input ready);
   modport sink (input valid, vert_x, vert_y, last_vertex, was_selected, output ready);
endinterface

>>> sv/psp_rsp_if.sv
interface psp_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic selected;

   modport source (output valid, hit, selected, input ready);
   modport sink (input valid, hit, selected, output ready);
endinterface

>>> sv/psp_csr_if.sv
interface psp_csr_if import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                      valid;
   logic                      ready;
   logic [CSR_ADDR_WIDTH-1:0] addr;
   logic [COORD_WIDTH-1:0]    data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

>>> sv/psp_front.sv
module psp_front import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] vert_x,
   input  logic signed [COORD_WIDTH-1:0] vert_y,
   input  logic                          last_vertex,
   input  logic                          was_selected,
   input  logic signed [COORD_WIDTH-1:0] pick_x,
   input  logic signed [COORD_WIDTH-1:0] pick_y,
   input  logic signed [COORD_WIDTH-1:0] rect_max_x,
   input  logic signed [COORD_WIDTH-1:0] rect_max_y,
   input  logic                          next_ready,
   output ctrl_type                      ctrl,
   output logic signed [COORD_WIDTH:0]   e_dx,
   output logic signed [COORD_WIDTH:0]   e_dy,
   output logic signed [COORD_WIDTH:0]   e_px,
   output logic signed [COORD_WIDTH:0]   e_py,
   output logic signed [COORD_WIDTH:0]   c_dx,
   output logic signed [COORD_WIDTH:0]   c_dy,
   output logic signed [COORD_WIDTH:0]   c_px,
   output logic signed [COORD_WIDTH:0]   c_py
);

   logic signed [COORD_WIDTH-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_WIDTH-1:0] first_x_in, first_y_in, prev_x_in, prev_y_in;
   logic [1:0]                    count_ff, count_in, count_sat;
   ctrl_type                      ctrl_ff, ctrl_in;
   logic signed [COORD_WIDTH:0]   e_dx_ff, e_dy_ff, e_px_ff, e_py_ff;
   logic signed [COORD_WIDTH:0]   c_dx_ff, c_dy_ff, c_px_ff, c_py_ff;
   logic signed [COORD_WIDTH-1:0] close_x, close_y;
   logic                          fire;

   function automatic logic signed [COORD_WIDTH:0] diff_ext(
      input logic signed [COORD_WIDTH-1:0] a,
      input logic signed [COORD_WIDTH-1:0] b
   );
      return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
   endfunction

   always_comb begin
      in_ready = !ctrl_ff.valid || next_ready;
      fire = in_valid && in_ready;
      close_x = (count_ff == '0) ? vert_x : first_x_ff;
      close_y = (count_ff == '0) ? vert_y : first_y_ff;
      count_sat = (count_ff == VERTEX_COUNT_MAX) ? VERTEX_COUNT_MAX : count_ff + 2'd1;

      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      count_in = count_ff;
      if (fire) begin
         if (last_vertex) begin
            first_x_in = '0;
            first_y_in = '0;
            prev_x_in = '0;
            prev_y_in = '0;
            count_in = '0;
         end else begin
            first_x_in = close_x;
            first_y_in = close_y;
            prev_x_in = vert_x;
            prev_y_in = vert_y;
            count_in = count_sat;
         end
      end

      ctrl_in = ctrl_ff;
      if (in_ready) begin
         ctrl_in.valid = in_valid;
         ctrl_in.last = last_vertex;
         ctrl_in.was_selected = was_selected;
         ctrl_in.edge_ok = (count_ff != '0);
         ctrl_in.enough = (count_sat > MIN_POLY_VERTS);
         ctrl_in.in_rect = (vert_x >= pick_x) && (vert_y >= pick_y) &&
                           (vert_x <= rect_max_x) && (vert_y <= rect_max_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
         count_ff <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         count_ff <= count_in;
         first_x_ff <= first_x_in;
         first_y_ff <= first_y_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
      end
   end

   // edge from previous vertex to this one, and closing edge back to the first
   always_ff @(posedge clock) begin
      if (in_ready) begin
         e_dx_ff <= diff_ext(vert_x, prev_x_ff);
         e_dy_ff <= diff_ext(vert_y, prev_y_ff);
         e_px_ff <= diff_ext(pick_x, prev_x_ff);
         e_py_ff <= diff_ext(pick_y, prev_y_ff);
         c_dx_ff <= diff_ext(close_x, vert_x);
         c_dy_ff <= diff_ext(close_y, vert_y);
         c_px_ff <= diff_ext(pick_x, vert_x);
         c_py_ff <= diff_ext(pick_y, vert_y);
      end
   end

   assign ctrl = ctrl_ff;
   assign e_dx = e_dx_ff;
   assign e_dy = e_dy_ff;
   assign e_px = e_px_ff;
   assign e_py = e_py_ff;
   assign c_dx = c_dx_ff;
   assign c_dy = c_dy_ff;
   assign c_px = c_px_ff;
   assign c_py = c_py_ff;

endmodule

>>> sv/psp_mult.sv
module psp_mult import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctrl_type                        in_ctrl,
   input  logic signed [COORD_WIDTH:0]     e_dx,
   input  logic signed [COORD_WIDTH:0]     e_dy,
   input  logic signed [COORD_WIDTH:0]     e_px,
   input  logic signed [COORD_WIDTH:0]     e_py,
   input  logic signed [COORD_WIDTH:0]     c_dx,
   input  logic signed [COORD_WIDTH:0]     c_dy,
   input  logic signed [COORD_WIDTH:0]     c_px,
   input  logic signed [COORD_WIDTH:0]     c_py,
   input  logic                            consume,
   output logic                            ready_up,
   output ctrl_type                        out_ctrl,
   output logic signed [2*COORD_WIDTH+1:0] e_a,
   output logic signed [2*COORD_WIDTH+1:0] e_b,
   output logic signed [2*COORD_WIDTH+1:0] c_a,
   output logic signed [2*COORD_WIDTH+1:0] c_b
);

   localparam int PW = 2*COORD_WIDTH + 2;

   ctrl_type                ctrl_ff, ctrl_in;
   logic signed [PW-1:0]    e_a_ff, e_b_ff, c_a_ff, c_b_ff;
   logic signed [PW-1:0]    e_a_in, e_b_in, c_a_in, c_b_in;

   always_comb begin
      ready_up = !ctrl_ff.valid || consume;
      ctrl_in = ready_up ? in_ctrl : ctrl_ff;
      e_a_in = PW'(e_py) * PW'(e_dx);
      e_b_in = PW'(e_px) * PW'(e_dy);
      c_a_in = PW'(c_py) * PW'(c_dx);
      c_b_in = PW'(c_px) * PW'(c_dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_up) begin
         e_a_ff <= e_a_in;
         e_b_ff <= e_b_in;
         c_a_ff <= c_a_in;
         c_b_ff <= c_b_in;
      end
   end

   assign out_ctrl = ctrl_ff;
   assign e_a = e_a_ff;
   assign e_b = e_b_ff;
   assign c_a = c_a_ff;
   assign c_b = c_b_ff;

endmodule

>>> sv/psp_decide.sv
module psp_decide import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ctrl_type                        in_ctrl,
   input  logic signed [2*COORD_WIDTH+1:0] e_a,
   input  logic signed [2*COORD_WIDTH+1:0] e_b,
   input  logic signed [2*COORD_WIDTH+1:0] c_a,
   input  logic signed [2*COORD_WIDTH+1:0] c_b,
   input  logic                            rect_mode,
   input  combine_type                     combine_mode,
   output logic                            consume,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            hit,
   output logic                            selected
);

   localparam int PW = 2*COORD_WIDTH + 2;

   logic              pos_ff, neg_ff, inside_ff;
   logic              pos_in, neg_in, inside_in;
   logic              valid_ff, valid_in, hit_ff, hit_in, sel_ff, sel_in;
   logic              out_free, e_pos, e_neg, c_pos, c_neg;
   logic              pos_acc, neg_acc, inside_acc, hit_now, sel_now;
   logic signed [PW:0] e_d, c_d;

   always_comb begin
      e_d = {e_a[PW-1], e_a} - {e_b[PW-1], e_b};
      c_d = {c_a[PW-1], c_a} - {c_b[PW-1], c_b};
      e_neg = e_d[PW];
      e_pos = !e_d[PW] && (e_d != '0);
      c_neg = c_d[PW];
      c_pos = !c_d[PW] && (c_d != '0);

      pos_acc = pos_ff && (!in_ctrl.edge_ok || e_pos) && (!in_ctrl.last || c_pos);
      neg_acc = neg_ff && (!in_ctrl.edge_ok || e_neg) && (!in_ctrl.last || c_neg);
      inside_acc = inside_ff && in_ctrl.in_rect;

      hit_now = rect_mode ? inside_acc : (in_ctrl.enough && (pos_acc || neg_acc));
      unique case (combine_mode)
         COMBINE_NEW:       sel_now = hit_now;
         COMBINE_JOIN:      sel_now = in_ctrl.was_selected || hit_now;
         COMBINE_INTERSECT: sel_now = in_ctrl.was_selected && hit_now;
         COMBINE_INVERT:    sel_now = hit_now ? !in_ctrl.was_selected : in_ctrl.was_selected;
         default:           sel_now = hit_now;
      endcase

      out_free = !valid_ff || rsp_ready;
      consume = in_ctrl.valid && (!in_ctrl.last || out_free);

      pos_in = pos_ff;
      neg_in = neg_ff;
      inside_in = inside_ff;
      if (consume) begin
         if (in_ctrl.last) begin
            pos_in = 1'b1;
            neg_in = 1'b1;
            inside_in = 1'b1;
         end else begin
            pos_in = pos_acc;
            neg_in = neg_acc;
            inside_in = inside_acc;
         end
      end

      valid_in = valid_ff && !rsp_ready;
      hit_in = hit_ff;
      sel_in = sel_ff;
      if (consume && in_ctrl.last) begin
         valid_in = 1'b1;
         hit_in = hit_now;
         sel_in = sel_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 1'b1;
         neg_ff <= 1'b1;
         inside_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         inside_ff <= inside_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      sel_ff <= sel_in;
   end

   assign rsp_valid = valid_ff;
   assign hit = hit_ff;
   assign selected = sel_ff;

endmodule

>>> sv/polygon_screen_pick_test.sv
// a result passes the edge difference registers (front), the cross product registers
// (mult) and the sign and combine registers (decide) before it is valid
// throughput: one vertex per cycle unless a waiting result is not taken; the output register frees the input side
// reset clears the polygon state, the setup registers and all valid flags at once
module polygon_screen_pick_test import psp_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   psp_req_if.sink   req_port,
   psp_rsp_if.source rsp_port,
   psp_csr_if.sink   csr_port
);

   logic                            rect_mode_ff;
   logic signed [COORD_WIDTH-1:0]   pick_x_ff, pick_y_ff, rect_max_x_ff, rect_max_y_ff;
   combine_type                     combine_mode_ff;

   ctrl_type                        f_ctrl, m_ctrl;
   logic signed [COORD_WIDTH:0]     e_dx, e_dy, e_px, e_py, c_dx, c_dy, c_px, c_py;
   logic signed [2*COORD_WIDTH+1:0] e_a, e_b, c_a, c_b;
   logic                            mult_ready, consume;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_mode_ff <= 1'b0;
         pick_x_ff <= '0;
         pick_y_ff <= '0;
         rect_max_x_ff <= '0;
         rect_max_y_ff <= '0;
         combine_mode_ff <= COMBINE_NEW;
      end else if (csr_port.valid) begin
         unique case (csr_port.addr)
            CSR_RECT_MODE:    rect_mode_ff <= csr_port.data[0];
            CSR_PICK_X:       pick_x_ff <= csr_port.data;
            CSR_PICK_Y:       pick_y_ff <= csr_port.data;
            CSR_RECT_MAX_X:   rect_max_x_ff <= csr_port.data;
            CSR_RECT_MAX_Y:   rect_max_y_ff <= csr_port.data;
            CSR_COMBINE_MODE: combine_mode_ff <= combine_type'(csr_port.data[1:0]);
            default:          ;
         endcase
      end
   end

   psp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_port.valid),
      .in_ready     (req_port.ready),
      .vert_x       (req_port.vert_x),
      .vert_y       (req_port.vert_y),
      .last_vertex  (req_port.last_vertex),
      .was_selected (req_port.was_selected),
      .pick_x       (pick_x_ff),
      .pick_y       (pick_y_ff),
      .rect_max_x   (rect_max_x_ff),
      .rect_max_y   (rect_max_y_ff),
      .next_ready   (mult_ready),
      .ctrl         (f_ctrl),
      .e_dx         (e_dx),
      .e_dy         (e_dy),
      .e_px         (e_px),
      .e_py         (e_py),
      .c_dx         (c_dx),
      .c_dy         (c_dy),
      .c_px         (c_px),
      .c_py         (c_py)
   );

   psp_mult #(.COORD_WIDTH(COORD_WIDTH)) u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_ctrl  (f_ctrl),
      .e_dx     (e_dx),
      .e_dy     (e_dy),
      .e_px     (e_px),
      .e_py     (e_py),
      .c_dx     (c_dx),
      .c_dy     (c_dy),
      .c_px     (c_px),
      .c_py     (c_py),
      .consume  (consume),
      .ready_up (mult_ready),
      .out_ctrl (m_ctrl),
      .e_a      (e_a),
      .e_b      (e_b),
      .c_a      (c_a),
      .c_b      (c_b)
   );

   psp_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
      .clock        (clock),
      .reset        (reset),
      .in_ctrl      (m_ctrl),
      .e_a          (e_a),
      .e_b          (e_b),
      .c_a          (c_a),
      .c_b          (c_b),
      .rect_mode    (rect_mode_ff),
      .combine_mode (combine_mode_ff),
      .consume      (consume),
      .rsp_valid    (rsp_port.valid),
      .rsp_ready    (rsp_port.ready),
      .hit          (rsp_port.hit),
      .selected     (rsp_port.selected)
   );

`ifndef ASSERT_OFF
   a_accept_fills_front: assert property (@(posedge clock) disable iff (reset)
      req_port.valid && req_port.ready |=> f_ctrl.valid)
      else $error("accepted request did not reach the first stage");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && !rsp_port.ready |-> !(consume && m_ctrl.last))
      else $error("waiting result overwritten");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(m_ctrl.valid && m_ctrl.last && consume))
      else $error("result without a last vertex");
`endif

endmodule

>>> sim/tb_polygon_screen_pick_test.sv
module tb_polygon_screen_pick_test import psp_pkg::*;;

   localparam int CW = COORD_WIDTH_DEF;
   localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
   localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      bit                   is_last;
      bit                   was;
   } vertex_type;

   typedef struct {
      bit hit;
      bit sel;
   } pick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psp_req_if #(.COORD_WIDTH(CW)) req_ch ();
   psp_rsp_if                     rsp_ch ();
   psp_csr_if #(.COORD_WIDTH(CW)) csr_ch ();

   polygon_screen_pick_test #(.COORD_WIDTH(CW)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   vertex_type      vertex_queue[$];
   pick_result_type pick_expected[$];
   int              pushed_total = 0;
   int              accepted_total = 0;
   int              error_count = 0;

   // predictor registers and polygon state
   bit                   cfg_rect_mode = 1'b0;
   logic signed [CW-1:0] cfg_pick_x = '0;
   logic signed [CW-1:0] cfg_pick_y = '0;
   logic signed [CW-1:0] cfg_max_x = '0;
   logic signed [CW-1:0] cfg_max_y = '0;
   combine_type          cfg_combine = COMBINE_NEW;

   longint     poly_first_x = 0, poly_first_y = 0, poly_prev_x = 0, poly_prev_y = 0;
   logic [1:0] poly_count = '0;
   bit         all_pos = 1'b1, all_neg = 1'b1, all_in = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp_coord(input longint v);
      return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   function automatic longint full_coord();
      logic signed [CW-1:0] r;
      r = CW'($urandom);
      return longint'(r);
   endfunction

   // sign of the cross product of the edge f->t against the pick point
   function automatic int cross_sign(input longint fx, fy, tx, ty);
      longint d;
      d = (longint'(cfg_pick_y) - fy) * (tx - fx) - (longint'(cfg_pick_x) - fx) * (ty - fy);
      return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
   endfunction

   task automatic pick_predict(input longint vx, vy, input bit is_last, was);
      bit              in_rect, hit, sel;
      int              s;
      pick_result_type res;
      in_rect = vx >= cfg_pick_x && vy >= cfg_pick_y && vx <= cfg_max_x && vy <= cfg_max_y;
      all_in = all_in && in_rect;
      if (poly_count == 0) begin
         poly_first_x = vx;
         poly_first_y = vy;
      end else begin
         s = cross_sign(poly_prev_x, poly_prev_y, vx, vy);
         all_pos = all_pos && s > 0;
         all_neg = all_neg && s < 0;
      end
      poly_prev_x = vx;
      poly_prev_y = vy;
      if (poly_count != VERTEX_COUNT_MAX)
         poly_count++;
      if (is_last) begin
         s = cross_sign(vx, vy, poly_first_x, poly_first_y);
         all_pos = all_pos && s > 0;
         all_neg = all_neg && s < 0;
         if (cfg_rect_mode)
            hit = all_in;
         else
            hit = poly_count > MIN_POLY_VERTS && (all_pos || all_neg);
         case (cfg_combine)
            COMBINE_NEW:       sel = hit;
            COMBINE_JOIN:      sel = was || hit;
            COMBINE_INTERSECT: sel = was && hit;
            default:           sel = hit ? !was : was;
         endcase
         res.hit = hit;
         res.sel = sel;
         pick_expected = {pick_expected, res};
         poly_first_x = 0;
         poly_first_y = 0;
         poly_prev_x = 0;
         poly_prev_y = 0;
         poly_count = '0;
         all_pos = 1'b1;
         all_neg = 1'b1;
         all_in = 1'b1;
      end
   endtask

   // request driver: bursts of random length with random gaps, sometimes none, between them
   bit         req_taken = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;
   vertex_type cur_vertex;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.vert_x = '0;
      req_ch.vert_y = '0;
      req_ch.last_vertex = 1'b0;
      req_ch.was_selected = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = CSR_RECT_MODE;
      csr_ch.data = '0;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         pick_predict(longint'(req_ch.vert_x), longint'(req_ch.vert_y),
                      req_ch.last_vertex, req_ch.was_selected);
         accepted_total++;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!req_ch.valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (!reset && vertex_queue.size() > 0) begin
            cur_vertex = vertex_queue.pop_front();
            req_ch.vert_x <= cur_vertex.x;
            req_ch.vert_y <= cur_vertex.y;
            req_ch.last_vertex <= cur_vertex.is_last;
            req_ch.was_selected <= cur_vertex.was;
            req_ch.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left--;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result side stalls with a density that changes each time rsp_slot wraps
   logic [4:0] rsp_slot = '0;
   int         rsp_density = 0;

   always @(negedge clock) begin
      if (rsp_slot == 0)
         rsp_density = $urandom_range(0, 3);
      rsp_slot++;
      rsp_ch.ready <= ($urandom_range(0, 3) >= rsp_density);
   end

   always @(posedge clock) begin
      pick_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pick_expected.size() == 0) begin
            $error("unexpected result: hit %0b selected %0b", rsp_ch.hit, rsp_ch.selected);
            error_count++;
         end else begin
            want = pick_expected.pop_front();
            if (rsp_ch.hit !== want.hit) begin
               $error("hit mismatch: expected %0b, actual %0b", want.hit, rsp_ch.hit);
               error_count++;
            end
            if (rsp_ch.selected !== want.sel) begin
               $error("selected mismatch: expected %0b, actual %0b", want.sel, rsp_ch.selected);
               error_count++;
            end
         end
      end
   end

   task automatic csr_write(input csr_addr_type idx, input longint value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.addr <= idx;
      csr_ch.data <= value[CW-1:0];
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_RECT_MODE:  cfg_rect_mode = value[0];
         CSR_PICK_X:     cfg_pick_x = value[CW-1:0];
         CSR_PICK_Y:     cfg_pick_y = value[CW-1:0];
         CSR_RECT_MAX_X: cfg_max_x = value[CW-1:0];
         CSR_RECT_MAX_Y: cfg_max_y = value[CW-1:0];
         default:        cfg_combine = combine_type'(value[1:0]);
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic write_setup(input bit rm, input longint px, py, mx, my,
                              input combine_type cm);
      csr_write(CSR_RECT_MODE, longint'(rm));
      csr_write(CSR_PICK_X, px);
      csr_write(CSR_PICK_Y, py);
      csr_write(CSR_RECT_MAX_X, mx);
      csr_write(CSR_RECT_MAX_Y, my);
      csr_write(CSR_COMBINE_MODE, longint'(cm));
   endtask

   // every request accepted, every result back, then latency slack
   task automatic wait_idle();
      @(negedge clock);
      while (accepted_total != pushed_total || pick_expected.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic push_vertex(input longint x, y, input bit is_last, was);
      vertex_type v;
      v.x = x[CW-1:0];
      v.y = y[CW-1:0];
      v.is_last = is_last;
      v.was = was;
      vertex_queue = {vertex_queue, v};
      pushed_total++;
   endtask

   // convex polygon on a circle, either orientation
   task automatic push_ring(input longint cx, cy, radius, input int n, input bit was);
      real base, step, th;
      int  dir;
      base = $urandom_range(0, 6283) / 1000.0;
      step = 6.283185307 / n;
      dir = $urandom_range(0, 1) ? 1 : -1;
      for (int i = 0; i < n; i++) begin
         th = base + dir * (i * step + step * $urandom_range(0, 40) / 100.0);
         push_vertex(clamp_coord(cx + longint'(radius * $cos(th))),
                     clamp_coord(cy + longint'(radius * $sin(th))), i == n - 1, was);
      end
   endtask

   task automatic random_phase(input int phase, input int n_items);
      longint px, py, mx, my, ccx, ccy, radius, half;
      bit     rm, was;
      int     target, n, kind, setup;
      setup = (phase < 2) ? phase : $urandom_range(2, 7);
      rm = (phase < 4) ? phase[0] == 0 : $urandom_range(0, 1);
      case (setup)
         0: begin
            px = COORD_MIN; py = COORD_MIN; mx = COORD_MAX; my = COORD_MAX;
         end
         1: begin
            px = COORD_MAX; py = COORD_MAX; mx = COORD_MAX; my = COORD_MAX;
         end
         2: begin
            px = longint'($urandom_range(0, 8000)) - 4000;
            py = longint'($urandom_range(0, 8000)) - 4000;
            mx = px - $urandom_range(1, 2000);
            my = py + $urandom_range(0, 2000);
         end
         default: begin
            px = ($urandom_range(0, 3) == 0) ? full_coord()
                                             : longint'($urandom_range(0, 8000)) - 4000;
            py = ($urandom_range(0, 3) == 0) ? full_coord()
                                             : longint'($urandom_range(0, 8000)) - 4000;
            mx = clamp_coord(px + $urandom_range(0, 4000));
            my = clamp_coord(py + $urandom_range(0, 4000));
         end
      endcase
      write_setup(rm, px, py, mx, my, combine_type'($urandom_range(0, 3)));
      target = pushed_total + n_items;
      while (pushed_total < target) begin
         was = $urandom_range(0, 1);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               push_vertex(full_coord(), full_coord(), i == n - 1, was);
         end else begin
            n = (kind == 1) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            if (rm) begin
               ccx = (px + mx) / 2;
               ccy = (py + my) / 2;
               half = ((mx - px > my - py) ? mx - px : my - py) / 2;
               if (half < 0)
                  half = -half;
               radius = (half + 1) * $urandom_range(30, 130) / 100;
            end else begin
               ccx = px;
               ccy = py;
               radius = ($urandom_range(0, 7) == 0) ? $urandom_range(1000, 300000)
                                                    : $urandom_range(1, 3000);
            end
            if ($urandom_range(0, 4) == 0) begin
               ccx += longint'($urandom_range(0, 2 * radius)) - radius;
               ccy += longint'($urandom_range(0, 2 * radius)) - radius;
            end
            push_ring(ccx, ccy, radius, n, was);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // point mode after reset, pick at origin
      push_vertex(-16, -16, 0, 0); push_vertex(16, -16, 0, 0); push_vertex(0, 16, 1, 0);
      push_vertex(0, 16, 0, 1); push_vertex(16, -16, 0, 1); push_vertex(-16, -16, 1, 1);
      push_vertex(5, 5, 1, 0);
      push_vertex(-16, 0, 0, 1); push_vertex(16, 0, 1, 1);
      // pick point on an edge
      push_vertex(0, 0, 0, 0); push_vertex(16, 0, 0, 0); push_vertex(0, 16, 1, 0);
      push_vertex(COORD_MIN, COORD_MIN, 0, 1); push_vertex(COORD_MAX, COORD_MIN, 0, 1);
      push_vertex(0, COORD_MAX, 1, 1);
      wait_idle();

      write_setup(1, -100, -100, 100, 100, COMBINE_JOIN);
      push_vertex(-100, -100, 0, 0); push_vertex(100, -100, 0, 0);
      push_vertex(100, 100, 0, 0); push_vertex(-100, 100, 1, 0);
      push_vertex(101, 0, 1, 1);
      wait_idle();

      // unordered rectangle
      write_setup(1, 100, -100, -100, 100, COMBINE_INTERSECT);
      push_vertex(0, 0, 1, 1);
      wait_idle();

      // mode change in the middle of a polygon
      write_setup(1, -100, -100, 100, 100, COMBINE_INVERT);
      push_vertex(-16, -16, 0, 1); push_vertex(16, -16, 0, 1);
      wait_idle();
      csr_write(CSR_RECT_MODE, 0);
      csr_write(CSR_PICK_X, 0);
      csr_write(CSR_PICK_Y, 0);
      push_vertex(0, 16, 1, 1);
      wait_idle();

      for (int p = 0; p < 10; p++)
         random_phase(p, 200);

      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
sv/psp_pkg.sv
sv/psp_req_if.sv
sv/psp_rsp_if.sv
sv/psp_csr_if.sv
sv/psp_front.sv
sv/psp_mult.sv
sv/psp_decide.sv
sv/polygon_screen_pick_test.sv
sim/tb_polygon_screen_pick_test.sv
